// File: rtl/itoaf_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps

package itoaf_pkg;

    localparam int VAL_W     = 64;
    localparam int WIDTH_CAP = 64;
    localparam int NUM_BCD   = 20;
    localparam int BCD_W     = NUM_BCD * 4;
    localparam int CHAR_W    = 8;
    localparam int FW_W      = 7;
    localparam int MD_W      = 6;
    localparam int NDIG_W    = 5;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic              sign_on;
        logic [CHAR_W-1:0] sign_char;
        logic              uppercase;
        logic              zero_pad;
        logic              left_align;
        logic [FW_W-1:0]   field_width;
        logic              has_precision;
        logic [MD_W-1:0]   min_digits;
    } fmt_cfg_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_SHIFT,
        C_SCAN
    } conv_state_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_PREP,
        E_EMIT
    } emit_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic up);
        logic [CHAR_W-1:0] ch;
        begin
            if (nib < 4'd10)
            begin
                ch = CH_ZERO + {4'b0, nib};
            end
            else
            begin
                ch = (up ? CH_UPPER_A : CH_LOWER_A) + {4'b0, nib} - 8'd10;
            end
            return ch;
        end
    endfunction

endpackage

// File: rtl/itoaf_conv.sv
// Digit converter: shift-add-3 binary to BCD, hex load, leading digit scan.
`timescale 1ns / 1ps

module itoaf_conv
    import itoaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              hex,
    input  logic [VAL_W-1:0]  mag,
    output logic              done,
    output logic [BCD_W-1:0]  digits,
    output logic [NDIG_W-1:0] ndig
);

    conv_state_t        state_reg, state_next;
    logic [VAL_W-1:0]   bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [5:0]         cnt_reg;
    logic [NDIG_W-1:0]  idx_reg;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         scan_nib;
    logic               scan_hit;

    always_comb
    begin
        for (int i = 0; i < NUM_BCD; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    assign scan_nib = bcd_reg[idx_reg*4 +: 4];
    assign scan_hit = (scan_nib != 4'd0) || (idx_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (go)
                begin
                    state_next = hex ? C_SCAN : C_SHIFT;
                end
            end
            C_SHIFT:
            begin
                if (cnt_reg == 6'(VAL_W - 1))
                begin
                    state_next = C_SCAN;
                end
            end
            C_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == C_SCAN) && scan_hit;
        ndig = idx_reg + NDIG_W'(1);
    end

    assign digits = bcd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                cnt_reg <= '0;
                idx_reg <= NDIG_W'(NUM_BCD - 1);
                if (go)
                begin
                    bin_reg <= mag;
                    bcd_reg <= hex ? {{(BCD_W - VAL_W){1'b0}}, mag} : '0;
                end
            end
            C_SHIFT:
            begin
                bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VAL_W-1]};
                bin_reg <= {bin_reg[VAL_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
            end
            C_SCAN:
            begin
                if (!scan_hit)
                begin
                    idx_reg <= idx_reg - NDIG_W'(1);
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule

// File: rtl/itoaf_emit.sv
// Character sequencer: padding, sign, precision zeros and digits, one per cycle.
`timescale 1ns / 1ps

module itoaf_emit
    import itoaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fmt_cfg_t          cfg,
    input  logic [BCD_W-1:0]  digits,
    input  logic [NDIG_W-1:0] ndig,
    output logic              strobe,
    output logic [CHAR_W-1:0] out_char,
    output logic              last_char
);

    emit_state_t        state_reg, state_next;
    fmt_cfg_t           cfg_reg;
    logic [NDIG_W-1:0]  ndig_reg;
    logic [MD_W-1:0]    nd_reg;
    logic [FW_W-1:0]    len_reg;
    logic [FW_W-1:0]    lead_reg;
    logic [FW_W-1:0]    zero_reg;
    logic [FW_W-1:0]    tail_reg;
    logic [NDIG_W-1:0]  dig_reg;
    logic               sign_reg;
    logic [FW_W-1:0]    tot_reg;

    logic [MD_W-1:0]    nd_calc;
    logic [FW_W-1:0]    pad;
    logic               zeros_mode;
    logic               use_lead, use_sign, use_zero, use_dig;
    logic [NDIG_W-1:0]  dig_idx;

    assign nd_calc = (cfg.has_precision && (cfg.min_digits > MD_W'(ndig))) ?
                     cfg.min_digits : MD_W'(ndig);
    assign pad = (cfg_reg.field_width > len_reg) ? (cfg_reg.field_width - len_reg) : '0;
    assign zeros_mode = cfg_reg.zero_pad && !cfg_reg.left_align;
    assign dig_idx = dig_reg - NDIG_W'(1);

    assign use_lead = (lead_reg != '0);
    assign use_sign = !use_lead && sign_reg;
    assign use_zero = !use_lead && !sign_reg && (zero_reg != '0);
    assign use_dig  = !use_lead && !sign_reg && (zero_reg == '0) && (dig_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (load)
                begin
                    state_next = E_PREP;
                end
            end
            E_PREP:
            begin
                state_next = E_EMIT;
            end
            E_EMIT:
            begin
                if (tot_reg == FW_W'(1))
                begin
                    state_next = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_comb
    begin
        strobe    = (state_reg == E_EMIT);
        last_char = (state_reg == E_EMIT) && (tot_reg == FW_W'(1));
        priority if (use_lead)
        begin
            out_char = CH_SPACE;
        end
        else if (use_sign)
        begin
            out_char = cfg_reg.sign_char;
        end
        else if (use_zero)
        begin
            out_char = CH_ZERO;
        end
        else if (use_dig)
        begin
            out_char = digit_char(digits[dig_idx*4 +: 4], cfg_reg.uppercase);
        end
        else
        begin
            out_char = CH_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            E_IDLE:
            begin
                if (load)
                begin
                    cfg_reg  <= cfg;
                    ndig_reg <= ndig;
                    nd_reg   <= nd_calc;
                    len_reg  <= FW_W'(nd_calc) + FW_W'(cfg.sign_on);
                end
            end
            E_PREP:
            begin
                lead_reg <= (!cfg_reg.left_align && !cfg_reg.zero_pad) ? pad : '0;
                zero_reg <= (zeros_mode ? pad : '0) + FW_W'(nd_reg - MD_W'(ndig_reg));
                tail_reg <= cfg_reg.left_align ? pad : '0;
                dig_reg  <= ndig_reg;
                sign_reg <= cfg_reg.sign_on;
                tot_reg  <= len_reg + pad;
            end
            E_EMIT:
            begin
                tot_reg <= tot_reg - FW_W'(1);
                priority if (use_lead)
                begin
                    lead_reg <= lead_reg - FW_W'(1);
                end
                else if (use_sign)
                begin
                    sign_reg <= 1'b0;
                end
                else if (use_zero)
                begin
                    zero_reg <= zero_reg - FW_W'(1);
                end
                else if (use_dig)
                begin
                    dig_reg <= dig_reg - NDIG_W'(1);
                end
                else
                begin
                    tail_reg <= tail_reg - FW_W'(1);
                end
            end
            default:
            begin
                sign_reg <= 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/integer_to_ascii_formatter_core.sv
// Top level of the integer to ASCII formatter.
`timescale 1ns / 1ps

// One transaction (start high while busy low) carries an integer and its
// printf-style settings; the block then stays busy and sends the formatted
// number as N characters on out_char, one per cycle with strobe high, the
// final one flagged by last_char. There is no backpressure: take every
// character in the cycle it is shown. While busy the block first runs the
// shift-add-3 unit (decimal only), then scans down to the top nonzero
// digit, passes through a setup state and then outputs the characters.
// busy drops the cycle after last_char.

module integer_to_ascii_formatter_core
    import itoaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [63:0]       value,
    input  logic              wide_operand,
    input  logic              is_signed,
    input  logic              hex_base,
    input  logic              uppercase,
    input  logic [6:0]        field_width,
    input  logic              has_precision,
    input  logic [5:0]        min_digits,
    input  logic              zero_pad,
    input  logic              left_align,
    input  logic              plus_sign,
    input  logic              space_sign,
    output logic              strobe,
    output logic [7:0]        out_char,
    output logic              last_char
);

    top_state_t         state_reg, state_next;
    fmt_cfg_t           cfg_reg, cfg_next;
    logic               accept;
    logic [VAL_W-1:0]   ext_val;
    logic               neg;
    logic [VAL_W-1:0]   mag;
    logic               conv_done;
    logic [BCD_W-1:0]   conv_digits;
    logic [NDIG_W-1:0]  conv_ndig;

    assign accept = start && (state_reg == T_IDLE);

    always_comb
    begin
        if (wide_operand)
        begin
            ext_val = value;
        end
        else if (is_signed && value[31])
        begin
            ext_val = {32'hffff_ffff, value[31:0]};
        end
        else
        begin
            ext_val = {32'h0, value[31:0]};
        end
        neg = is_signed && ext_val[VAL_W-1];
        mag = neg ? (~ext_val + VAL_W'(1)) : ext_val;

        cfg_next.sign_on       = neg || (is_signed && (plus_sign || space_sign));
        cfg_next.sign_char     = neg ? CH_MINUS : (plus_sign ? CH_PLUS : CH_SPACE);
        cfg_next.uppercase     = uppercase;
        cfg_next.zero_pad      = zero_pad;
        cfg_next.left_align    = left_align;
        cfg_next.field_width   = (field_width > FW_W'(WIDTH_CAP)) ?
                                 FW_W'(WIDTH_CAP) : field_width;
        cfg_next.has_precision = has_precision;
        cfg_next.min_digits    = min_digits;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    state_next = T_CONV;
                end
            end
            T_CONV:
            begin
                if (conv_done)
                begin
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (strobe && last_char)
                begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != T_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cfg_reg <= cfg_next;
        end
    end

    itoaf_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (accept),
        .hex    (hex_base),
        .mag    (mag),
        .done   (conv_done),
        .digits (conv_digits),
        .ndig   (conv_ndig)
    );

    itoaf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (conv_done && (state_reg == T_CONV)),
        .cfg       (cfg_reg),
        .digits    (conv_digits),
        .ndig      (conv_ndig),
        .strobe    (strobe),
        .out_char  (out_char),
        .last_char (last_char)
    );

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character strobe while idle");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_char |-> strobe)
        else $error("last_char without strobe");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |=> !busy)
        else $error("busy held after final character");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("transaction accepted without going busy");
`endif

endmodule
